@@ hw/rtl/pss_pkg.sv @@
// Shared types, codes and constants for the page source selector.
// No dependencies; imported by every module of the block.
package pss_pkg;

  // Largest run the table takes.
  localparam int MAX_SOURCES = 8;
  localparam int CNT_W = $clog2(MAX_SOURCES + 1);
  localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  localparam int ID_W    = 64;
  localparam int VER_W   = 64;
  localparam int FLAGS_W = 9;
  localparam int SEL_W   = 3;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    KIND_CURRENT    = 2'd0,
    KIND_PAST_IMAGE = 2'd1,
    KIND_STORAGE    = 2'd2,
    KIND_UNKNOWN    = 2'd3
  } kind_t;

  // Rank uses the kind encoding; unknown doubles as "none yet".
  localparam logic [1:0] RANK_NONE = 2'd3;

  typedef enum logic [1:0] {
    STAT_SELECTED  = 2'd0,
    STAT_NO_VALID  = 2'd1,
    STAT_CONFLICT  = 2'd2,
    STAT_TOO_MANY  = 2'd3
  } status_t;

  // Required proof flags per kind.
  localparam logic [FLAGS_W-1:0] FLAGS_CURRENT    = 9'h00F;
  localparam logic [FLAGS_W-1:0] FLAGS_PAST_IMAGE = 9'h01F;
  localparam logic [FLAGS_W-1:0] FLAGS_STORAGE    = 9'h1E5;

  typedef struct packed {
    kind_t              kind;
    logic [ID_W-1:0]    identity;
    logic [VER_W-1:0]   version;
    logic               version_ok;
    logic [FLAGS_W-1:0] proof_flags;
    logic               last;
  } cand_t;

  typedef struct packed {
    status_t          status;
    logic [SEL_W-1:0] selected_index;
  } res_t;

  function automatic logic [FLAGS_W-1:0] need_flags(kind_t k);
    logic [FLAGS_W-1:0] need;
    unique case (k)
      KIND_CURRENT:    need = FLAGS_CURRENT;
      KIND_PAST_IMAGE: need = FLAGS_PAST_IMAGE;
      KIND_STORAGE:    need = FLAGS_STORAGE;
      default:         need = '1;
    endcase
    return need;
  endfunction

  // Index masked to the result field width.
  function automatic logic [SEL_W-1:0] to_sel_idx(logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SEL_W-1:0];
  endfunction

endpackage

@@ hw/rtl/pss_in_reg.sv @@
// Input register stage for candidate requests.
// Depends on pss_pkg for the candidate struct.
module pss_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  pss_pkg::cand_t up_cand,
  output logic           dn_valid,
  input  logic           dn_ready,
  output pss_pkg::cand_t dn_cand
);
  import pss_pkg::*;

  logic  valid_r;
  cand_t cand_r;

  // Refill whenever empty or draining this cycle.
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_cand  = cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cand_r <= up_cand;
    end
  end

endmodule

@@ hw/rtl/pss_run_acc.sv @@
// Candidate judging, run accumulation and the result register.
// Depends on pss_pkg for types, codes and flag masks.
module pss_run_acc (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pss_pkg::ID_W-1:0]  expected_identity,
  input  logic                      cand_valid,
  output logic                      cand_ready,
  input  pss_pkg::cand_t            cand,
  output logic                      res_valid,
  input  logic                      res_ready,
  output pss_pkg::res_t             res
);
  import pss_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             any_valid_r, any_valid_nxt;
  logic [VER_W-1:0] ref_ver_r, ref_ver_nxt;
  logic             conflict_r, conflict_nxt;
  logic [1:0]       best_rank_r, best_rank_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;

  logic             res_valid_r;
  res_t             res_r, res_nxt;

  logic             out_free;
  logic             fire;
  logic             judged_ok;
  logic             full;

  assign out_free   = !res_valid_r || res_ready;
  // Non-last requests never touch the result register.
  assign cand_ready = !cand.last || out_free;
  assign fire       = cand_valid && cand_ready;

  assign judged_ok = cand.version_ok && (cand.identity == expected_identity) &&
                     (cand.kind != KIND_UNKNOWN) &&
                     ((cand.proof_flags & need_flags(cand.kind)) == need_flags(cand.kind));
  assign full = (cnt_r >= CNT_W'(MAX_SOURCES));

  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    any_valid_nxt = any_valid_r;
    ref_ver_nxt   = ref_ver_r;
    conflict_nxt  = conflict_r;
    best_rank_nxt = best_rank_r;
    best_idx_nxt  = best_idx_r;
    res_nxt       = res_r;

    if (full) begin
      ovf_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (judged_ok) begin
        if (!any_valid_r) begin
          any_valid_nxt = 1'b1;
          ref_ver_nxt   = cand.version;
          best_rank_nxt = cand.kind;
          best_idx_nxt  = cnt_r[IDX_W-1:0];
        end else begin
          if (cand.version != ref_ver_r) conflict_nxt = 1'b1;
          if (cand.kind < best_rank_r) begin
            best_rank_nxt = cand.kind;
            best_idx_nxt  = cnt_r[IDX_W-1:0];
          end
        end
      end
    end

    res_nxt.selected_index = '0;
    priority if (ovf_nxt) begin
      res_nxt.status = STAT_TOO_MANY;
    end else if (!any_valid_nxt) begin
      res_nxt.status = STAT_NO_VALID;
    end else if (conflict_nxt) begin
      res_nxt.status = STAT_CONFLICT;
    end else begin
      res_nxt.status         = STAT_SELECTED;
      res_nxt.selected_index = to_sel_idx(best_idx_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      any_valid_r <= 1'b0;
      ref_ver_r   <= '0;
      conflict_r  <= 1'b0;
      best_rank_r <= RANK_NONE;
      best_idx_r  <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      if (fire) begin
        if (cand.last) begin
          // Report and start a fresh run.
          res_valid_r <= 1'b1;
          cnt_r       <= '0;
          ovf_r       <= 1'b0;
          any_valid_r <= 1'b0;
          ref_ver_r   <= '0;
          conflict_r  <= 1'b0;
          best_rank_r <= RANK_NONE;
          best_idx_r  <= '0;
        end else begin
          cnt_r       <= cnt_nxt;
          ovf_r       <= ovf_nxt;
          any_valid_r <= any_valid_nxt;
          ref_ver_r   <= ref_ver_nxt;
          conflict_r  <= conflict_nxt;
          best_rank_r <= best_rank_nxt;
          best_idx_r  <= best_idx_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cand.last) res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cand.last) |=> (cnt_r == '0) && !any_valid_r && !ovf_r && !conflict_r)
    else $error("run state not cleared after result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SOURCES))
    else $error("item count beyond table size");

  a_rank_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    any_valid_r == (best_rank_r != RANK_NONE))
    else $error("best rank out of step with valid flag");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && (res_r.status != STAT_SELECTED)) |-> (res_r.selected_index == '0))
    else $error("index set on non-selected outcome");

endmodule

@@ hw/rtl/page_source_selector.sv @@
// Page source selector top level: config register, stream packing, stages.
// Depends on pss_pkg, pss_in_reg and pss_run_acc.
// The result for a run passes the input register and then the result register.
// Throughput: one candidate request per cycle, except while in_tready is low.
// in_tready drops only while a last request waits on a full result register.
// Reset (rst_n, synchronous, active low) clears the run state and the identity register.
module page_source_selector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pss_pkg::ID_W-1:0]           cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata, low bit up: identity[63:0], version[127:64], version_ok[128],
  // proof_flags[137:129], zero pad[143:138]
  input  logic [pss_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]                         in_tuser,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata, low bit up: selected_index[2:0], zero pad[7:3]
  output logic [pss_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: status[1:0]
  output logic [1:0]                         out_tuser
);
  import pss_pkg::*;

  logic [ID_W-1:0] expected_identity_r;

  cand_t in_cand;
  cand_t stg_cand;
  logic  stg_valid;
  logic  stg_ready;
  res_t  res;

  // Expected identity; to be written only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_identity_r <= '0;
    end else if (cfg_we) begin
      expected_identity_r <= cfg_wdata;
    end
  end

  // Unpack the request stream.
  always_comb begin
    in_cand.kind        = kind_t'(in_tuser);
    in_cand.identity    = in_tdata[ID_W-1:0];
    in_cand.version     = in_tdata[ID_W+VER_W-1:ID_W];
    in_cand.version_ok  = in_tdata[ID_W+VER_W];
    in_cand.proof_flags = in_tdata[ID_W+VER_W+FLAGS_W:ID_W+VER_W+1];
    in_cand.last        = in_tlast;
  end

  pss_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_cand  (in_cand),
    .dn_valid (stg_valid),
    .dn_ready (stg_ready),
    .dn_cand  (stg_cand)
  );

  pss_run_acc u_run_acc (
    .clk               (clk),
    .rst_n             (rst_n),
    .expected_identity (expected_identity_r),
    .cand_valid        (stg_valid),
    .cand_ready        (stg_ready),
    .cand              (stg_cand),
    .res_valid         (out_tvalid),
    .res_ready         (out_tready),
    .res               (res)
  );

  // Pack the result stream.
  assign out_tdata = {(OUT_TDATA_W - SEL_W)'(0), res.selected_index};
  assign out_tuser = res.status;

endmodule
